// ===== hw/rtl/vlio_pkg.sv =====
package vlio_pkg;

  // Request commands.
  localparam logic [1:0] CMD_IO_READ   = 2'd0;
  localparam logic [1:0] CMD_IO_WRITE  = 2'd1;
  localparam logic [1:0] CMD_Q0_EVENT  = 2'd2;
  localparam logic [1:0] CMD_Q1_EVENT  = 2'd3;

  // Register offsets in the I/O window after the MSI-X remap.
  localparam logic [4:0] OFF_FEATURES   = 5'h00;
  localparam logic [4:0] OFF_QUEUE_PAGE = 5'h08;
  localparam logic [4:0] OFF_QUEUE_SIZE = 5'h0C;
  localparam logic [4:0] OFF_QUEUE_SEL  = 5'h0E;
  localparam logic [4:0] OFF_NOTIFY     = 5'h10;
  localparam logic [4:0] OFF_STATUS     = 5'h12;
  localparam logic [4:0] OFF_ISR        = 5'h13;
  localparam logic [4:0] OFF_MAC_FIRST  = 5'h14;
  localparam logic [4:0] OFF_MAC_LAST   = 5'h19;
  localparam logic [4:0] OFF_MSIX_FIRST = 5'h14;
  localparam logic [4:0] OFF_MSIX_END   = 5'h18;
  localparam logic [4:0] MSIX_SHIFT     = 5'h04;

  // Offsets inside the MSI-X vector window.
  localparam logic [4:0] OFF_CONFIG_VEC = 5'h14;
  localparam logic [4:0] OFF_QUEUE_VEC  = 5'h16;

  // Device constants.
  localparam logic [31:0] FEATURE_MAC   = 32'h0000_0020;
  localparam int unsigned QUEUE_ENTRIES = 256;
  localparam int unsigned VECTOR_COUNT  = 3;
  localparam logic [15:0] VECTOR_NONE   = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STATION_MAC   = 2'd0;
  localparam logic [1:0] CFG_MSIX_ON       = 2'd1;
  localparam logic [1:0] CFG_INTX_DISABLED = 2'd2;

  // Byte lane mask for an access of 1 to 4 bytes.
  function automatic logic [31:0] byte_mask(input logic [2:0] n);
    logic [31:0] m;
    case (n)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/vlio_if.sv =====
// Request channel: one bus access or queue completion event.
interface vlio_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [4:0]  port_offset;
  logic [2:0]  access_bytes;
  logic [31:0] write_data;

  modport source (output valid, command, port_offset, access_bytes, write_data,
                  input ready);
  modport sink (input valid, command, port_offset, access_bytes, write_data,
                output ready);
endinterface

// Result channel: read data, interrupt line pulses and ready status.
interface vlio_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        line_enable;
  logic        line_disable;
  logic        line_clear;
  logic        line_assert;
  logic        tx_kick;
  logic        device_ready;

  modport source (output valid, read_data, line_enable, line_disable, line_clear,
                  line_assert, tx_kick, device_ready,
                  input ready);
  modport sink (input valid, read_data, line_enable, line_disable, line_clear,
                line_assert, tx_kick, device_ready,
                output ready);
endinterface

// ===== hw/rtl/virtio_legacy_io_registers_top.sv =====
// Legacy virtio-net I/O register block. Each request on req is a bus read, a bus
// write or a queue completion event, and produces exactly one result on rsp. A
// request is decoded and applied to the register state in the cycle it is
// accepted, and its result is held in an output register, so one request is
// taken every cycle while rsp keeps up; the block stalls req only when a result
// is still waiting and rsp is not ready. With MSI-X enabled, offsets 0x14-0x17
// select the vector registers and higher offsets move down by four. Reading the
// interrupt status register clears one pending flag per read, queue 0 first.
// The configuration registers (MAC address, MSI-X enable, INTx disable) sit at
// byte addresses 0x00, 0x08 and 0x10 of the APB port and take effect at once.
module virtio_legacy_io_registers_top
  import vlio_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  vlio_req_if.sink    req,
  vlio_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [47:0] station_mac;
  logic        msix_on;
  logic        intx_disabled;

  // Device registers.
  logic [31:0] queue_page [2];
  logic [15:0] queue_select;
  logic [7:0]  device_status;
  logic        ready_flag;
  logic        pending_rx;
  logic        pending_tx;
  logic [15:0] config_vector;
  logic [15:0] queue_vector [2];

  // Next values.
  logic [31:0] queue_page_next [2];
  logic [15:0] queue_select_next;
  logic [7:0]  device_status_next;
  logic        ready_flag_next;
  logic        pending_rx_next;
  logic        pending_tx_next;
  logic [15:0] config_vector_next;
  logic [15:0] queue_vector_next [2];

  // Output register.
  logic        out_valid;
  logic [31:0] read_data;
  logic        line_enable;
  logic        line_disable;
  logic        line_clear;
  logic        line_assert;
  logic        tx_kick;
  logic        device_ready;

  // Decode signals.
  logic        in_fire;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [2:0]  size;
  logic [2:0]  vec_size;
  logic [31:0] size_mask;
  logic [31:0] vec_mask;
  logic        vec_window;
  logic [4:0]  eff_port;
  logic        q;
  logic        select_ok;
  logic [7:0]  lo;
  logic [47:0] mac_shifted;
  logic [31:0] rd;
  logic        en;
  logic        dis;
  logic        clr;
  logic        asrt;
  logic        kick;

  // Handshakes.
  assign in_fire   = req.valid && req.ready;
  assign req.ready = !out_valid || rsp.ready;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[4:3];
  assign pready    = 1'b1;

  // Configuration read back.
  always_comb begin
    unique case (cfg_index)
      CFG_STATION_MAC:   prdata = {16'd0, station_mac};
      CFG_MSIX_ON:       prdata = {63'd0, msix_on};
      CFG_INTX_DISABLED: prdata = {63'd0, intx_disabled};
      default:           prdata = 64'd0;
    endcase
  end

  // Access size clamp: zero acts as one byte, above four acts as four.
  always_comb begin
    if (req.access_bytes == 3'd0) begin
      size = 3'd1;
    end else if (req.access_bytes > 3'd4) begin
      size = 3'd4;
    end else begin
      size = req.access_bytes;
    end
    vec_size  = (size == 3'd1) ? 3'd1 : 3'd2;
    size_mask = byte_mask(size);
    vec_mask  = byte_mask(vec_size);
  end

  // MSI-X remap of the port offset.
  always_comb begin
    vec_window = 1'b0;
    eff_port   = req.port_offset;
    if (msix_on && req.port_offset >= OFF_MSIX_FIRST) begin
      if (req.port_offset < OFF_MSIX_END) begin
        vec_window = 1'b1;
      end else begin
        eff_port = req.port_offset - MSIX_SHIFT;
      end
    end
  end

  assign q           = queue_select[0];
  assign select_ok   = (queue_select < 16'd2);
  assign lo          = req.write_data[7:0];
  assign mac_shifted = station_mac >> {eff_port - OFF_MAC_FIRST, 3'b000};

  // Register decode and state update for one request.
  always_comb begin
    queue_page_next    = queue_page;
    queue_select_next  = queue_select;
    device_status_next = device_status;
    ready_flag_next    = ready_flag;
    pending_rx_next    = pending_rx;
    pending_tx_next    = pending_tx;
    config_vector_next = config_vector;
    queue_vector_next  = queue_vector;
    rd   = 32'd0;
    en   = 1'b0;
    dis  = 1'b0;
    clr  = 1'b0;
    asrt = 1'b0;
    kick = 1'b0;

    case (req.command)
      CMD_IO_READ: begin
        if (vec_window) begin
          if (eff_port == OFF_CONFIG_VEC) begin
            rd = {16'd0, config_vector} & vec_mask;
          end else if (eff_port == OFF_QUEUE_VEC) begin
            if (!select_ok || queue_vector[q] >= 16'(VECTOR_COUNT)) begin
              rd = vec_mask;
            end else begin
              rd = {16'd0, queue_vector[q]} & vec_mask;
            end
          end
        end else begin
          unique case (eff_port) inside
            OFF_FEATURES:   rd = FEATURE_MAC;
            OFF_QUEUE_PAGE: rd = queue_page[q];
            OFF_QUEUE_SIZE: begin
              if (size > 3'd1 && select_ok) begin
                rd = {16'd0, 16'(QUEUE_ENTRIES)};
              end
            end
            OFF_QUEUE_SEL:  rd = {16'd0, queue_select};
            OFF_STATUS:     rd = {24'd0, device_status};
            OFF_ISR: begin
              // One pending flag is cleared per read, queue 0 first.
              clr = 1'b1;
              if (pending_rx) begin
                pending_rx_next = 1'b0;
                rd = 32'd1;
              end else if (pending_tx) begin
                pending_tx_next = 1'b0;
                rd = 32'd1;
              end
            end
            [OFF_MAC_FIRST:OFF_MAC_LAST]: rd = mac_shifted[31:0];
            default: rd = 32'd0;
          endcase
        end
        rd = rd & size_mask;
      end

      CMD_IO_WRITE: begin
        if (vec_window) begin
          if (eff_port == OFF_CONFIG_VEC) begin
            config_vector_next = (config_vector & ~vec_mask[15:0])
                               | (req.write_data[15:0] & vec_mask[15:0]);
          end else if (eff_port == OFF_QUEUE_VEC && select_ok) begin
            queue_vector_next[q] = (queue_vector[q] & ~vec_mask[15:0])
                                 | (req.write_data[15:0] & vec_mask[15:0]);
          end
        end else begin
          unique case (eff_port)
            OFF_QUEUE_PAGE: begin
              queue_page_next[q] = (queue_page[q] & ~size_mask)
                                 | (req.write_data & size_mask);
            end
            OFF_NOTIFY: begin
              // A zero write marks the driver ready, anything else kicks transmit.
              if (lo == 8'd0) begin
                en = !intx_disabled || msix_on;
                ready_flag_next = 1'b1;
              end else begin
                kick = 1'b1;
              end
            end
            OFF_STATUS: begin
              if (lo != 8'd0) begin
                device_status_next = device_status | lo;
              end else begin
                device_status_next = 8'd0;
                ready_flag_next = 1'b0;
                dis = 1'b1;
              end
            end
            OFF_QUEUE_SEL: begin
              queue_select_next = (size == 3'd1) ? {8'd0, lo} : req.write_data[15:0];
            end
            default: ;
          endcase
        end
      end

      CMD_Q0_EVENT: begin
        pending_rx_next = 1'b1;
        asrt = 1'b1;
      end

      default: begin
        pending_tx_next = 1'b1;
        asrt = 1'b1;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      station_mac   <= 48'd0;
      msix_on       <= 1'b0;
      intx_disabled <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STATION_MAC:   station_mac   <= pwdata[47:0];
        CFG_MSIX_ON:       msix_on       <= pwdata[0];
        CFG_INTX_DISABLED: intx_disabled <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Device state, updated on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      queue_page[0]   <= 32'd0;
      queue_page[1]   <= 32'd0;
      queue_select    <= 16'd0;
      device_status   <= 8'd0;
      ready_flag      <= 1'b0;
      pending_rx      <= 1'b0;
      pending_tx      <= 1'b0;
      config_vector   <= VECTOR_NONE;
      queue_vector[0] <= VECTOR_NONE;
      queue_vector[1] <= VECTOR_NONE;
    end else if (in_fire) begin
      queue_page    <= queue_page_next;
      queue_select  <= queue_select_next;
      device_status <= device_status_next;
      ready_flag    <= ready_flag_next;
      pending_rx    <= pending_rx_next;
      pending_tx    <= pending_tx_next;
      config_vector <= config_vector_next;
      queue_vector  <= queue_vector_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      read_data    <= rd;
      line_enable  <= en;
      line_disable <= dis;
      line_clear   <= clr;
      line_assert  <= asrt;
      tx_kick      <= kick;
      device_ready <= ready_flag_next;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_data    = read_data;
  assign rsp.line_enable  = line_enable;
  assign rsp.line_disable = line_disable;
  assign rsp.line_clear   = line_clear;
  assign rsp.line_assert  = line_assert;
  assign rsp.tx_kick      = tx_kick;
  assign rsp.device_ready = device_ready;

endmodule

// ===== test/virtio_legacy_io_registers_top_tb.sv =====
`timescale 1ns / 100ps

module virtio_legacy_io_registers_top_tb;
  import vlio_pkg::*;

  localparam int unsigned PHASES       = 7;
  localparam int unsigned PHASE_ITEMS  = 250;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned LONG_STALL   = 400;
  localparam int unsigned MAX_SHOWN    = 60;
  // Offsets at or above this value stand for the MSI-X vector window.
  localparam int unsigned VEC_WINDOW   = 'h100;

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  port_offset;
    logic [2:0]  access_bytes;
    logic [31:0] write_data;
  } io_request_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        line_enable;
    logic        line_disable;
    logic        line_clear;
    logic        line_assert;
    logic        tx_kick;
    logic        device_ready;
  } io_reply_t;

  typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_BEAT, SINK_SLOW} sink_style_e;

  // Shadow copy of the register file; it works out the reply to each request
  // and compares the replies that come back in order.
  class io_reg_scoreboard;
    logic [47:0] mac;
    bit          msix_en;
    bit          intx_off;
    logic [31:0] page [2];
    logic [15:0] qsel;
    logic [7:0]  status;
    bit          ready_flag;
    bit          rx_pending;
    bit          tx_pending;
    logic [15:0] cfg_vec;
    logic [15:0] q_vec [2];
    io_reply_t   reply_q [$];
    int unsigned errors, shown, n_checked;
    int unsigned n_reads, n_writes, n_events, n_isr_hits, n_kicks;

    function new();
      mac = '0;
      msix_en = 0;
      intx_off = 0;
      page[0] = '0;
      page[1] = '0;
      qsel = '0;
      status = '0;
      ready_flag = 0;
      rx_pending = 0;
      tx_pending = 0;
      cfg_vec = VECTOR_NONE;
      q_vec[0] = VECTOR_NONE;
      q_vec[1] = VECTOR_NONE;
    endfunction

    function logic [31:0] lanes(int unsigned n);
      return (n >= 4) ? 32'hFFFF_FFFF : (32'h1 << (8 * n)) - 32'h1;
    endfunction

    function logic [31:0] merge_lanes(logic [31:0] old, logic [31:0] val, int unsigned n);
      return (old & ~lanes(n)) | (val & lanes(n));
    endfunction

    function void set_register(logic [1:0] idx, logic [63:0] value);
      case (idx)
        CFG_STATION_MAC:   mac = value[47:0];
        CFG_MSIX_ON:       msix_en = value[0];
        CFG_INTX_DISABLED: intx_off = value[0];
        default: ;
      endcase
    endfunction

    // Applies one accepted request to the shadow state and queues its reply.
    function void note_request(io_request_t rq);
      io_reply_t   r;
      int unsigned n, vn, p, k, m;
      bit          q;
      logic [7:0]  lo;
      r = '0;
      n = (rq.access_bytes == 0) ? 1 : (rq.access_bytes > 4) ? 4 : rq.access_bytes;
      vn = (n == 1) ? 1 : 2;
      q = qsel[0];
      lo = rq.write_data[7:0];
      p = rq.port_offset;
      // With MSI-X on, the first four bytes above the ISR hold the vectors.
      if (msix_en && p >= OFF_MSIX_FIRST)
        p = (p < OFF_MSIX_END) ? p + VEC_WINDOW : p - MSIX_SHIFT;

      case (rq.command)
        CMD_IO_READ: begin
          n_reads++;
          if (p == OFF_FEATURES) begin
            r.read_data = FEATURE_MAC;
          end else if (p == OFF_QUEUE_PAGE) begin
            r.read_data = page[q];
          end else if (p == OFF_QUEUE_SIZE) begin
            if (n > 1 && qsel < 2)
              r.read_data = QUEUE_ENTRIES & 32'h0000_FFFF;
          end else if (p == OFF_QUEUE_SEL) begin
            r.read_data = qsel;
          end else if (p == OFF_STATUS) begin
            r.read_data = status;
          end else if (p == OFF_ISR) begin
            // One pending flag is cleared per read, queue 0 first.
            r.line_clear = 1'b1;
            if (rx_pending) begin
              rx_pending = 0;
              r.read_data = 1;
              n_isr_hits++;
            end else if (tx_pending) begin
              tx_pending = 0;
              r.read_data = 1;
              n_isr_hits++;
            end
          end else if (p >= OFF_MAC_FIRST && p <= OFF_MAC_LAST) begin
            k = p - OFF_MAC_FIRST;
            m = 6 - k;
            if (m > n)
              m = n;
            r.read_data = 32'(mac >> (8 * k)) & lanes(m);
          end else if (p == VEC_WINDOW + OFF_CONFIG_VEC) begin
            r.read_data = cfg_vec & lanes(vn);
          end else if (p == VEC_WINDOW + OFF_QUEUE_VEC) begin
            if (qsel >= 2 || q_vec[q] >= VECTOR_COUNT)
              r.read_data = lanes(vn);
            else
              r.read_data = q_vec[q] & lanes(vn);
          end
          r.read_data &= lanes(n);
        end
        CMD_IO_WRITE: begin
          n_writes++;
          if (p == OFF_QUEUE_PAGE) begin
            page[q] = merge_lanes(page[q], rq.write_data, n);
          end else if (p == OFF_NOTIFY) begin
            if (lo == 0) begin
              if (!intx_off || msix_en)
                r.line_enable = 1'b1;
              ready_flag = 1;
            end else begin
              r.tx_kick = 1'b1;
              n_kicks++;
            end
          end else if (p == OFF_STATUS) begin
            if (lo != 0) begin
              status |= lo;
            end else begin
              status = '0;
              r.line_disable = 1'b1;
              ready_flag = 0;
            end
          end else if (p == OFF_QUEUE_SEL) begin
            qsel = (n == 1) ? {8'h00, lo} : rq.write_data[15:0];
          end else if (p == VEC_WINDOW + OFF_CONFIG_VEC) begin
            cfg_vec = 16'(merge_lanes(cfg_vec, rq.write_data, vn));
          end else if (p == VEC_WINDOW + OFF_QUEUE_VEC) begin
            if (qsel < 2)
              q_vec[q] = 16'(merge_lanes(q_vec[q], rq.write_data, vn));
          end
        end
        CMD_Q0_EVENT: begin
          n_events++;
          rx_pending = 1;
          r.line_assert = 1'b1;
        end
        default: begin
          n_events++;
          tx_pending = 1;
          r.line_assert = 1'b1;
        end
      endcase
      r.device_ready = ready_flag;
      reply_q.push_back(r);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (shown < MAX_SHOWN) begin
          shown++;
          $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
      end
    endfunction

    function void check_result(io_reply_t got);
      io_reply_t want;
      if (reply_q.size() == 0) begin
        errors++;
        if (shown < MAX_SHOWN) begin
          shown++;
          $display("%0t: reply with no request outstanding: expected none, actual %h",
                   $time, got);
        end
        return;
      end
      want = reply_q.pop_front();
      n_checked++;
      field_check("read_data", want.read_data, got.read_data);
      field_check("line_enable", want.line_enable, got.line_enable);
      field_check("line_disable", want.line_disable, got.line_disable);
      field_check("line_clear", want.line_clear, got.line_clear);
      field_check("line_assert", want.line_assert, got.line_assert);
      field_check("tx_kick", want.tx_kick, got.tx_kick);
      field_check("device_ready", want.device_ready, got.device_ready);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  vlio_req_if req ();
  vlio_rsp_if rsp ();

  io_reg_scoreboard board = new();
  io_request_t      plan [$];
  sink_style_e      sink_style = SINK_ALWAYS;
  int unsigned      hold_off_len = 0;
  int unsigned      cycle_count = 0;
  int unsigned      n_settings = 0;

  virtio_legacy_io_registers_top dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d replies outstanding", $time, board.reply_q.size());
      $display("** virtio_legacy_io_registers_top: FAILED **");
      $finish;
    end
  end

  // Every reply taken from the block is checked against the oldest request.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      board.check_result(io_reply_t'{rsp.read_data, rsp.line_enable, rsp.line_disable,
                                     rsp.line_clear, rsp.line_assert, rsp.tx_kick,
                                     rsp.device_ready});
  end

  // Reply side: stalls on its own pattern, with an occasional long hold-off.
  initial begin : result_sink
    int unsigned beat, stall_left;
    beat = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len != 0) begin
        stall_left = hold_off_len;
        hold_off_len = 0;
        rsp.ready <= 1'b0;
        repeat (stall_left) @(posedge clk);
      end
      beat++;
      case (sink_style)
        SINK_ALWAYS: rsp.ready <= 1'b1;
        SINK_RANDOM: rsp.ready <= ($urandom_range(0, 3) != 0);
        SINK_BEAT:   rsp.ready <= ((beat % 5) < 3);
        default:     rsp.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Register write on the configuration port: a setup phase, then an access phase.
  task automatic write_register(logic [1:0] idx, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    board.set_register(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offers one request and returns at the edge that accepts it.
  task automatic send_request(io_request_t rq);
    req.valid <= 1'b1;
    req.command <= rq.command;
    req.port_offset <= rq.port_offset;
    req.access_bytes <= rq.access_bytes;
    req.write_data <= rq.write_data;
    do @(posedge clk); while (req.ready !== 1'b1);
    board.note_request(rq);
  endtask

  task automatic issue(logic [1:0] cmd, logic [4:0] port, logic [2:0] size, logic [31:0] data);
    send_request(io_request_t'{cmd, port, size, data});
  endtask

  // Stops offering and waits until every reply has come back.
  task automatic go_idle();
    req.valid <= 1'b0;
    while (board.reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(logic [47:0] mac_val, bit msix_val, bit intx_val);
    write_register(CFG_STATION_MAC, {16'h0000, mac_val});
    write_register(CFG_MSIX_ON, {63'd0, msix_val});
    write_register(CFG_INTX_DISABLED, {63'd0, intx_val});
    n_settings++;
  endtask

  // Mostly legal sizes, sometimes the odd ones.
  function automatic logic [2:0] pick_size();
    case ($urandom_range(0, 9))
      0, 1, 2: return 3'd1;
      3, 4, 5: return 3'd2;
      6, 7:    return 3'd4;
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [4:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return OFF_FEATURES;
      1:       return OFF_QUEUE_PAGE;
      2:       return OFF_QUEUE_SIZE;
      3:       return OFF_QUEUE_SEL;
      4:       return OFF_NOTIFY;
      5:       return OFF_STATUS;
      6:       return OFF_ISR;
      7:       return OFF_MAC_FIRST + 5'($urandom_range(0, 9));
      default: return 5'($urandom);
    endcase
  endfunction

  // Adds either a driver-like queue set-up sequence or a lone random request.
  function automatic void plan_more(bit vec_on);
    io_request_t rq;
    logic [15:0] sel;
    if ($urandom_range(0, 9) < 6) begin
      sel = ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
      plan.push_back(io_request_t'{CMD_IO_WRITE, OFF_QUEUE_SEL, pick_size(),
                                   {16'($urandom), sel}});
      plan.push_back(io_request_t'{CMD_IO_WRITE, OFF_QUEUE_PAGE, pick_size(), $urandom});
      plan.push_back(io_request_t'{CMD_IO_READ, OFF_QUEUE_PAGE, 3'd4, $urandom});
      plan.push_back(io_request_t'{CMD_IO_READ, OFF_QUEUE_SIZE, pick_size(), $urandom});
      if (vec_on) begin
        plan.push_back(io_request_t'{CMD_IO_WRITE, OFF_QUEUE_VEC, pick_size(),
                                     {16'($urandom), 16'($urandom_range(0, 4))}});
        plan.push_back(io_request_t'{CMD_IO_READ, OFF_QUEUE_VEC, pick_size(), $urandom});
        plan.push_back(io_request_t'{CMD_IO_WRITE, OFF_CONFIG_VEC, pick_size(), $urandom});
        plan.push_back(io_request_t'{CMD_IO_READ, OFF_CONFIG_VEC, pick_size(), $urandom});
      end
      plan.push_back(io_request_t'{CMD_IO_WRITE, OFF_STATUS, pick_size(),
                                   {24'($urandom), 8'($urandom_range(1, 255))}});
      plan.push_back(io_request_t'{CMD_IO_WRITE, OFF_NOTIFY, pick_size(),
                                   {24'($urandom), 8'h00}});
      plan.push_back(io_request_t'{CMD_IO_WRITE, OFF_NOTIFY, pick_size(), $urandom});
      plan.push_back(io_request_t'{($urandom_range(0, 1) != 0) ? CMD_Q0_EVENT : CMD_Q1_EVENT,
                                   5'($urandom), 3'($urandom), $urandom});
      plan.push_back(io_request_t'{CMD_IO_READ, OFF_ISR, pick_size(), $urandom});
      plan.push_back(io_request_t'{CMD_IO_READ, OFF_ISR, pick_size(), $urandom});
      if ($urandom_range(0, 3) == 0)
        plan.push_back(io_request_t'{CMD_IO_WRITE, OFF_STATUS, pick_size(),
                                     {24'($urandom), 8'h00}});
    end else begin
      rq.command = ($urandom_range(0, 9) < 5) ? CMD_IO_READ :
                   ($urandom_range(0, 9) < 8) ? CMD_IO_WRITE :
                   ($urandom_range(0, 1) != 0) ? CMD_Q0_EVENT : CMD_Q1_EVENT;
      rq.port_offset = pick_offset();
      rq.access_bytes = pick_size();
      rq.write_data = $urandom;
      // Keep low write bytes interesting for the select, notify and status registers.
      if ($urandom_range(0, 9) < 4)
        rq.write_data[7:0] = '0;
      else if ($urandom_range(0, 9) < 5)
        rq.write_data[15:0] = 16'($urandom_range(0, 4));
      plan.push_back(rq);
    end
  endfunction

  initial begin : stimulus
    io_request_t rq;
    int unsigned sent, burst, gap;
    logic [47:0] mac_val;
    bit          msix_val, intx_val, calm;

    rst <= 1'b1;
    req.valid <= 1'b0;
    req.command <= CMD_IO_READ;
    req.port_offset <= OFF_FEATURES;
    req.access_bytes <= 3'd1;
    req.write_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests with INTx allowed and MSI-X off.
    apply_settings(48'hA1B2_C3D4_E5F6, 1'b0, 1'b0);
    issue(CMD_IO_READ, OFF_FEATURES, 3'd4, '0);
    issue(CMD_IO_READ, OFF_QUEUE_SIZE, 3'd2, '0);
    issue(CMD_IO_READ, OFF_QUEUE_SIZE, 3'd1, '0);
    issue(CMD_IO_WRITE, OFF_QUEUE_PAGE, 3'd4, 32'hFFFF_FFFF);
    issue(CMD_IO_WRITE, OFF_QUEUE_SEL, 3'd1, 32'hFFFF_FF01);
    issue(CMD_IO_WRITE, OFF_QUEUE_PAGE, 3'd2, 32'hDEAD_1234);
    issue(CMD_IO_READ, OFF_QUEUE_PAGE, 3'd0, '0);
    issue(CMD_IO_WRITE, OFF_QUEUE_SEL, 3'd4, 32'h0001_0002);
    issue(CMD_IO_READ, OFF_QUEUE_SIZE, 3'd4, '0);
    issue(CMD_IO_WRITE, OFF_STATUS, 3'd1, 32'h0000_0007);
    issue(CMD_IO_READ, OFF_STATUS, 3'd7, '0);
    issue(CMD_IO_WRITE, OFF_NOTIFY, 3'd2, 32'h0000_0100);
    issue(CMD_IO_WRITE, OFF_NOTIFY, 3'd1, 32'h0000_00FF);
    issue(CMD_IO_WRITE, OFF_STATUS, 3'd1, 32'hFFFF_FF00);
    issue(CMD_Q1_EVENT, 5'h1F, 3'd7, 32'hFFFF_FFFF);
    issue(CMD_Q0_EVENT, OFF_FEATURES, 3'd0, '0);
    issue(CMD_IO_READ, OFF_ISR, 3'd1, '0);
    issue(CMD_IO_READ, OFF_ISR, 3'd1, '0);
    issue(CMD_IO_READ, OFF_ISR, 3'd4, '0);
    issue(CMD_IO_READ, OFF_MAC_FIRST, 3'd4, '0);
    issue(CMD_IO_READ, OFF_MAC_LAST, 3'd4, '0);
    issue(CMD_IO_READ, 5'h1F, 3'd4, '0);
    issue(CMD_IO_WRITE, OFF_FEATURES, 3'd4, 32'hFFFF_FFFF);
    issue(CMD_IO_READ, OFF_FEATURES, 3'd3, '0);
    go_idle();

    // Directed requests through the MSI-X vector window.
    apply_settings(48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);
    issue(CMD_IO_WRITE, OFF_NOTIFY, 3'd1, '0);
    issue(CMD_IO_WRITE, OFF_QUEUE_SEL, 3'd2, '0);
    issue(CMD_IO_WRITE, OFF_QUEUE_VEC, 3'd2, 32'hFFFF_0002);
    issue(CMD_IO_READ, OFF_QUEUE_VEC, 3'd2, '0);
    issue(CMD_IO_WRITE, OFF_QUEUE_VEC, 3'd1, 32'h0000_0007);
    issue(CMD_IO_READ, OFF_QUEUE_VEC, 3'd4, '0);
    issue(CMD_IO_WRITE, OFF_CONFIG_VEC, 3'd1, '0);
    issue(CMD_IO_READ, OFF_CONFIG_VEC, 3'd4, '0);
    issue(CMD_IO_READ, OFF_MSIX_END, 3'd4, '0);
    go_idle();

    // Random phases, each under its own register setting and flow pattern.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          mac_val = '0;
          msix_val = 1'b0;
          intx_val = 1'b1;
        end
        1: begin
          mac_val = '1;
          msix_val = 1'b1;
          intx_val = 1'b0;
        end
        2: begin
          mac_val = {16'($urandom), 32'($urandom)};
          msix_val = 1'b1;
          intx_val = 1'b1;
        end
        3: begin
          mac_val = {16'($urandom), 32'($urandom)};
          msix_val = 1'b0;
          intx_val = 1'b0;
        end
        default: begin
          mac_val = {16'($urandom), 32'($urandom)};
          msix_val = 1'($urandom);
          intx_val = 1'($urandom);
        end
      endcase
      apply_settings(mac_val, msix_val, intx_val);
      sink_style = sink_style_e'(ph % 4);
      calm = (ph == 0 || ph == 4);
      // Hold replies back for a long while so that the request side backs up.
      if (ph == 2)
        hold_off_len = LONG_STALL;

      sent = 0;
      burst = $urandom_range(1, 24);
      plan.delete();
      while (sent < PHASE_ITEMS) begin
        if (plan.size() == 0)
          plan_more(msix_val);
        rq = plan.pop_front();
        send_request(rq);
        sent++;
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 24);
          gap = calm ? 0 : $urandom_range(0, 6);
          if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
      go_idle();
    end

    $display("Covered %0d requests (%0d reads, %0d writes, %0d events) over %0d settings.",
             board.n_reads + board.n_writes + board.n_events, board.n_reads,
             board.n_writes, board.n_events, n_settings);
    $display("Checked %0d replies; %0d status reads cleared a flag, %0d transmit kicks.",
             board.n_checked, board.n_isr_hits, board.n_kicks);
    if (board.errors == 0 && board.reply_q.size() == 0) begin
      $display("** virtio_legacy_io_registers_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d replies missing", board.errors, board.reply_q.size());
      $display("** virtio_legacy_io_registers_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/vlio_pkg.sv
hw/rtl/vlio_if.sv
hw/rtl/virtio_legacy_io_registers_top.sv
test/virtio_legacy_io_registers_top_tb.sv
